// ===== rtl/srm_pkg.sv =====
// ----------------------------------------------------------------------------
// srm_pkg - shared types and constants of the sorted run merge router
// Holds the run count, index widths, the head record type and the mapping
// from overlap kind to destination mask.
// ----------------------------------------------------------------------------
package srm_pkg;

   // Number of run slots the block is built for
   localparam int RUN_COUNT  = 16;
   // Runs reachable through the 4-bit run index
   localparam int RUN_IDX_W  = 4;
   localparam int IDX_REACH  = 1 << RUN_IDX_W;
   // Runs that can actually take part
   localparam int LIVE_MAX   = (RUN_COUNT < IDX_REACH) ? RUN_COUNT : IDX_REACH;
   localparam int ADDR_W     = $clog2(LIVE_MAX);
   // Count width, wide enough for a run index plus one
   localparam int CNT_W      = RUN_IDX_W + 1;
   localparam int CSR_W      = 5;

   // Field widths
   localparam int SUB_W      = 20;
   localparam int KEY_W      = 64;
   localparam int KIND_W     = 2;
   localparam int TAG_W      = 32;
   localparam int MASK_W     = 3;
   localparam int DATA_W     = 128;

   // Item functions
   localparam logic FUNC_OFFER = 1'b0;
   localparam logic FUNC_END   = 1'b1;

   // Overlap kinds
   localparam logic [KIND_W-1:0] KIND_CHUNK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SELF  = 2'd1;

   // Destination masks
   localparam logic [MASK_W-1:0] MASK_CHUNK     = 3'b001;
   localparam logic [MASK_W-1:0] MASK_SELF_FULL = 3'b110;
   localparam logic [MASK_W-1:0] MASK_FULL      = 3'b100;

   typedef struct packed {
      logic [SUB_W-1:0]  sub_chunk;
      logic [KEY_W-1:0]  sort_key;   // two's complement
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
   } head_type;

   // Control from the sequencer to the scan unit
   typedef struct packed {
      logic              start;
      logic              cmp_vld;
      logic [ADDR_W-1:0] idx;
      logic              ended;
      logic              valid;
   } scan_ctl_type;

   // Running result of a scan
   typedef struct packed {
      logic              all_ended;
      logic              all_ready;
      logic              have_best;
      logic [ADDR_W-1:0] best_idx;
   } scan_res_type;

   function automatic logic [MASK_W-1:0] mask_for(input logic [KIND_W-1:0] kind);
      logic [MASK_W-1:0] m;
      if (kind == KIND_CHUNK) begin
         m = MASK_CHUNK;
      end else if (kind == KIND_SELF) begin
         m = MASK_SELF_FULL;
      end else begin
         m = MASK_FULL;
      end
      return m;
   endfunction

endpackage

// ===== rtl/srm_head_mem.sv =====
// ----------------------------------------------------------------------------
// srm_head_mem - head record storage
// One write port for offered heads, one registered read port for the scan.
// ----------------------------------------------------------------------------
module srm_head_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [srm_pkg::ADDR_W-1:0] wr_addr,
   input  srm_pkg::head_type        wr_data,
   input  logic [srm_pkg::ADDR_W-1:0] rd_addr,
   output srm_pkg::head_type        rd_data
);
   import srm_pkg::*;

   head_type mem [LIVE_MAX];
   head_type rd_data_ff;

   // Store an offered head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srm_scan_unit.sv =====
// ----------------------------------------------------------------------------
// srm_scan_unit - shared head comparator
// Takes one run head per cycle, keeps the least head seen so far and the
// ended / ready summary of the runs scanned.
// ----------------------------------------------------------------------------
module srm_scan_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  srm_pkg::scan_ctl_type ctl,
   input  srm_pkg::head_type    head,
   output srm_pkg::scan_res_type res,
   output srm_pkg::head_type    best
);
   import srm_pkg::*;

   scan_res_type res_ff, res_in;
   head_type     best_ff, best_in;
   logic         sub_lt;
   logic         sub_eq;
   logic         key_lt;
   logic         head_first;

   // Order by sub-chunk, then by signed key; equal keeps the earlier run
   assign sub_lt     = head.sub_chunk < best_ff.sub_chunk;
   assign sub_eq     = head.sub_chunk == best_ff.sub_chunk;
   assign key_lt     = $signed(head.sort_key) < $signed(best_ff.sort_key);
   assign head_first = sub_lt || (sub_eq && key_lt);

   // Fold the current run into the summary
   always_comb begin
      res_in  = res_ff;
      best_in = best_ff;
      if (ctl.start) begin
         res_in.all_ended = 1'b1;
         res_in.all_ready = 1'b1;
         res_in.have_best = 1'b0;
      end else if (ctl.cmp_vld && !ctl.ended) begin
         res_in.all_ended = 1'b0;
         if (!ctl.valid) begin
            res_in.all_ready = 1'b0;
         end else if (!res_ff.have_best || head_first) begin
            res_in.have_best = 1'b1;
            res_in.best_idx  = ctl.idx;
            best_in          = head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign res  = res_ff;
   assign best = best_ff;

endmodule

// ===== rtl/sorted_run_merge_router.sv =====
// ----------------------------------------------------------------------------
// sorted_run_merge_router - k-way merge of sorted record runs
// Holds one head record per run and emits the least head once every run
// that has not ended holds one; emits a done marker when the last run ends.
//
// Usage:
//   req_* carries one word per item: req_tuser selects offer (0) or end (1),
//   req_tdata holds the run index and the record. csr_wr_en / csr_wr_data
//   set the number of active runs n (0 acts as 1, large values saturate).
//   rsp_* returns a record with its refill run and destination mask, or a
//   done marker flagged by rsp_tuser.
// Timing:
//   An item that is ignored (run out of range, offer to a full or ended run,
//   end of a full or ended run) leaves the run flags unchanged. For any
//   other item one comparator walks the n run heads from the head memory,
//   one per cycle, the drain state lets the read pipe empty and the decide
//   state decides; the result word enters the output register in the cycle
//   after that. req_tready is high only while the sequencer is idle; a
//   result waiting in the output register does not block the next item, but
//   a new result waits in the decide step until the output register is free.
// Reset clears all run flags, sets n to 1 and empties the output register.
// ----------------------------------------------------------------------------
module sorted_run_merge_router (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // active_runs
   // Item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [127:0] req_tdata,    // run_index, sub_chunk, sort_key,
                                      // overlap_kind, record_tag, zero fill
   input  logic [0:0]  req_tuser,     // func
   // Result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [127:0] rsp_tdata,    // refill_run, out_sub_chunk,
                                      // out_sort_key, destination_mask,
                                      // out_tag, zero fill
   output logic [0:0]  rsp_tuser      // merge_done
);
   import srm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     csr_ff, csr_in;
   logic [LIVE_MAX-1:0]  hvalid_ff, hvalid_in;
   logic [LIVE_MAX-1:0]  ended_ff, ended_in;
   logic                 ended_now_ff, ended_now_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic [CNT_W-1:0]     live_n;
   logic                 req_func;
   logic [RUN_IDX_W-1:0] req_run;
   logic [ADDR_W-1:0]    req_addr;
   head_type             req_head;
   logic                 accept;
   logic                 run_ok;
   logic                 item_legal;
   logic                 out_free;
   logic                 scan_last;
   logic                 mem_wr_en;
   head_type             rd_head;
   scan_ctl_type         scan_ctl;
   scan_res_type         scan_res;
   head_type             best_head;

   // Unpack the input word
   assign req_func           = req_tuser[0];
   assign req_run            = req_tdata[3:0];
   assign req_head.sub_chunk = req_tdata[23:4];
   assign req_head.sort_key  = req_tdata[87:24];
   assign req_head.kind      = req_tdata[89:88];
   assign req_head.tag       = req_tdata[121:90];
   assign req_addr           = req_run[ADDR_W-1:0];

   // Clamp the active run count to 1..LIVE_MAX
   always_comb begin
      if (csr_ff == '0) begin
         live_n = CNT_W'(1);
      end else if (csr_ff > CSR_W'(LIVE_MAX)) begin
         live_n = CNT_W'(LIVE_MAX);
      end else begin
         live_n = CNT_W'(csr_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign run_ok     = {1'b0, req_run} < live_n;
   assign item_legal = run_ok && !ended_ff[req_addr] && !hvalid_ff[req_addr];
   assign mem_wr_en  = accept && item_legal && (req_func == FUNC_OFFER);
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign scan_last  = (rd_cnt_ff == live_n - CNT_W'(1));

   // Configuration register
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         csr_in = csr_wr_data;
      end
   end

   // Sequencer, run flags and output register
   always_comb begin
      state_in     = state_ff;
      hvalid_in    = hvalid_ff;
      ended_in     = ended_ff;
      ended_now_in = ended_now_ff;
      rd_cnt_in    = rd_cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = rd_cnt_ff[ADDR_W-1:0];
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && item_legal) begin
               if (req_func == FUNC_OFFER) begin
                  hvalid_in[req_addr] = 1'b1;
                  ended_now_in        = 1'b0;
               end else begin
                  ended_in[req_addr]  = 1'b1;
                  ended_now_in        = 1'b1;
               end
               rd_cnt_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one head read per cycle
            cmp_vld_in = 1'b1;
            rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (scan_res.all_ended) begin
               if (!ended_now_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_vld_in  = 1'b1;
                  rsp_data_in = '0;
                  rsp_done_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (!scan_res.all_ready || !scan_res.have_best) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               hvalid_in[scan_res.best_idx] = 1'b0;
               rsp_vld_in           = 1'b1;
               rsp_data_in          = '0;
               rsp_data_in[3:0]     = RUN_IDX_W'(scan_res.best_idx);
               rsp_data_in[23:4]    = best_head.sub_chunk;
               rsp_data_in[87:24]   = best_head.sort_key;
               rsp_data_in[90:88]   = mask_for(best_head.kind);
               rsp_data_in[122:91]  = best_head.tag;
               rsp_done_in          = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         csr_ff     <= CSR_W'(1);
         hvalid_ff  <= '0;
         ended_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         csr_ff     <= csr_in;
         hvalid_ff  <= hvalid_in;
         ended_ff   <= ended_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload and scan bookkeeping
   always_ff @(posedge clock) begin
      ended_now_ff <= ended_now_in;
      rd_cnt_ff    <= rd_cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Feed the comparator with the run whose head just came out of memory
   assign scan_ctl.start   = accept;
   assign scan_ctl.cmp_vld = cmp_vld_ff;
   assign scan_ctl.idx     = cmp_idx_ff;
   assign scan_ctl.ended   = ended_ff[cmp_idx_ff];
   assign scan_ctl.valid   = hvalid_ff[cmp_idx_ff];

   srm_head_mem u_head_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_addr),
      .wr_data (req_head),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_head)
   );

   srm_scan_unit u_scan_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .head  (rd_head),
      .res   (scan_res),
      .best  (best_head)
   );

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_done_ff;

endmodule

// ===== tb/srm_merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_merge_checker - result checker for the sorted run merge router
// Watches the item, result and configuration ports, keeps its own copy of
// the run heads and run flags, works out the word each accepted item should
// produce and compares every accepted result word against the oldest one.
// ----------------------------------------------------------------------------
module srm_merge_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   output int           mismatch_count,
   output int           awaited_count
);
   import srm_pkg::*;

   localparam int PRINT_CAP = 200;

   typedef struct packed {
      logic              done;
      logic [3:0]        run;
      logic [SUB_W-1:0]  sub_chunk;
      logic [KEY_W-1:0]  sort_key;
      logic [MASK_W-1:0] mask;
      logic [TAG_W-1:0]  tag;
   } merge_word_type;

   merge_word_type expected_words[$];
   logic [4:0]     run_setting;
   logic           holds_head[RUN_COUNT];
   logic           run_closed[RUN_COUNT];
   head_type       heads[RUN_COUNT];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   // Print one line per bad word, up to PRINT_CAP lines, and count every one
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Number of runs taking part: zero acts as one, large values saturate
   function automatic int live_runs();
      int n;
      n = run_setting;
      if (n == 0) n = 1;
      if (n > LIVE_MAX) n = LIVE_MAX;
      return n;
   endfunction

   function automatic logic [MASK_W-1:0] dest_mask(input logic [KIND_W-1:0] kind);
      logic [MASK_W-1:0] m;
      case (kind)
         KIND_CHUNK: m = MASK_CHUNK;
         KIND_SELF:  m = MASK_SELF_FULL;
         default:    m = MASK_FULL;
      endcase
      return m;
   endfunction

   // True when head a sorts strictly ahead of head b
   function automatic bit orders_first(input int a, input int b);
      if (heads[a].sub_chunk != heads[b].sub_chunk) begin
         return heads[a].sub_chunk < heads[b].sub_chunk;
      end
      return $signed(heads[a].sort_key) < $signed(heads[b].sort_key);
   endfunction

   // Apply one accepted item and queue the word it produces, if any
   task automatic merge_item(input logic func, input logic [3:0] run,
                             input head_type rec);
      int             n;
      int             best;
      bit             all_closed;
      bit             all_full;
      bit             found;
      bit             just_closed;
      merge_word_type w;
      n = live_runs();
      best = 0;
      all_closed = 1'b1;
      all_full = 1'b1;
      found = 1'b0;
      just_closed = 1'b0;
      w = '0;
      // Drop items for inactive runs, ended runs and full runs
      if (run >= n) return;
      if (run_closed[run] || holds_head[run]) return;
      if (func == FUNC_OFFER) begin
         holds_head[run] = 1'b1;
         heads[run] = rec;
      end else begin
         run_closed[run] = 1'b1;
         just_closed = 1'b1;
      end
      // Scan the live runs for the least head, lower index winning ties
      for (int i = 0; i < n; i++) begin
         if (!run_closed[i]) begin
            all_closed = 1'b0;
            if (!holds_head[i]) begin
               all_full = 1'b0;
            end else if (!found || orders_first(i, best)) begin
               best = i;
               found = 1'b1;
            end
         end
      end
      if (all_closed) begin
         if (just_closed) begin
            w.done = 1'b1;
            expected_words.insert(expected_words.size(), w);
         end
         return;
      end
      if (!all_full || !found) return;
      holds_head[best] = 1'b0;
      w.run       = best[3:0];
      w.sub_chunk = heads[best].sub_chunk;
      w.sort_key  = heads[best].sort_key;
      w.mask      = dest_mask(heads[best].kind);
      w.tag       = heads[best].tag;
      expected_words.insert(expected_words.size(), w);
   endtask

   // Compare one result word field by field with the oldest expectation
   task automatic check_word(input logic [127:0] data, input logic done_flag);
      merge_word_type want;
      string          wrong;
      wrong = "";
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("unexpected word: run %0d done %0b tdata %h",
                                   data[3:0], done_flag, data));
         return;
      end
      want = expected_words.pop_front();
      if (done_flag !== want.done)        wrong = {wrong, " merge_done"};
      if (data[3:0] !== want.run)         wrong = {wrong, " refill_run"};
      if (data[23:4] !== want.sub_chunk)  wrong = {wrong, " sub_chunk"};
      if (data[87:24] !== want.sort_key)  wrong = {wrong, " sort_key"};
      if (data[90:88] !== want.mask)      wrong = {wrong, " destination_mask"};
      if (data[122:91] !== want.tag)      wrong = {wrong, " tag"};
      if (wrong != "") begin
         report_mismatch($sformatf(
            "bad%s: got tdata %h done %0b, want run %0d sub %h key %h mask %b tag %h done %0b",
            wrong, data, done_flag, want.run, want.sub_chunk, want.sort_key,
            want.mask, want.tag, want.done));
      end
   endtask

   // Track configuration, predict on item words, check result words
   always @(posedge clock) begin
      if (reset) begin
         run_setting = 5'd1;
         for (int i = 0; i < RUN_COUNT; i++) begin
            holds_head[i] = 1'b0;
            run_closed[i] = 1'b0;
         end
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_word(rsp_tdata, rsp_tuser[0]);
         end
         if (csr_wr_en) begin
            run_setting = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            merge_item(req_tuser[0], req_tdata[3:0],
                       '{req_tdata[23:4], req_tdata[87:24], req_tdata[89:88],
                         req_tdata[121:90]});
         end
      end
      awaited_count <= expected_words.size();
   end

endmodule

// ===== tb/tb_sorted_run_merge_router.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_run_merge_router - testbench for the sorted run merge router
// Drives a short directed list covering key extremes, ties, every overlap
// kind and the ignored-item cases, then full random merges over the
// remaining runs, refilling each run the block asks for, mixed with ignored
// noise words, across several run counts and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_sorted_run_merge_router;
   import srm_pkg::*;

   localparam int IDLE_SETTLE = LIVE_MAX + 8;
   localparam int DRAIN_LIMIT = 20000;

   // Overlap kinds the block has no name for
   localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [4:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   int           mismatch_count;
   int           awaited_count;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           merge_live;
   logic [4:0]   refill_requests[$];   // {merge_done, refill_run}

   sorted_run_merge_router u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   srm_merge_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Record which run each accepted result word asks to refill
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         refill_requests.insert(refill_requests.size(), {rsp_tuser[0], rsp_tdata[3:0]});
      end
   end

   // Present one item word and hold it until accepted
   task automatic send_item(input logic func, input logic [3:0] run,
                            input logic [SUB_W-1:0] sub, input logic [KEY_W-1:0] key,
                            input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'b0, tag, kind, key, sub, run};
      do @(posedge clock); while (!req_tready);
   endtask

   // Write the run count; only called while the block is idle
   task automatic set_active_runs(input logic [4:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Hold off until every expected word is back and the block has settled
   task automatic drain_to_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_count != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Wait for the next result word seen on the result side
   task automatic next_refill(output logic [4:0] entry);
      if (refill_requests.size() == 0) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while (refill_requests.size() == 0) @(negedge clock);
         @(posedge clock);
      end
      entry = refill_requests.pop_front();
   endtask

   // Bias toward small values so ties and near ties are common
   function automatic logic [SUB_W-1:0] rand_sub();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return SUB_W'($urandom_range(0, 3));
      if (pick == 4) return ($urandom_range(0, 1) != 0) ? {SUB_W{1'b1}} : '0;
      return SUB_W'($urandom);
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      v = int'($urandom_range(0, 6)) - 3;
      if (pick < 4) return {{32{v[31]}}, v};
      if (pick == 4) begin
         return ($urandom_range(0, 1) != 0) ? 64'h7FFF_FFFF_FFFF_FFFF
                                            : 64'h8000_0000_0000_0000;
      end
      return {$urandom, $urandom};
   endfunction

   task automatic send_offer(input logic [3:0] run);
      send_item(FUNC_OFFER, run, rand_sub(), rand_key(),
                KIND_W'($urandom_range(0, 3)), $urandom);
   endtask

   // Send a word the block must ignore: any run but the one being refilled
   task automatic send_noise(input logic [3:0] avoid);
      logic [3:0] run;
      do run = 4'($urandom_range(0, 15)); while (run == avoid);
      send_item(($urandom_range(0, 1) != 0) ? FUNC_END : FUNC_OFFER, run,
                rand_sub(), rand_key(), KIND_W'($urandom_range(0, 3)), $urandom);
   endtask

   // Merge over runs lo..hi: fill every head, then refill each run the block
   // asks for until the budget is spent; with close_out, end the runs after
   task automatic run_merge(input int lo, input int hi, input int budget,
                            input bit fill, input bit close_out);
      int         sent;
      logic [4:0] entry;
      logic [3:0] run;
      sent = 0;
      if (fill) begin
         merge_live = hi - lo + 1;
         for (int i = lo; i <= hi; i++) begin
            send_offer(4'(i));
            sent++;
         end
      end
      while (1) begin
         if (!close_out && sent >= budget) break;
         next_refill(entry);
         if (entry[4]) break;
         run = entry[3:0];
         if ($urandom_range(0, 99) < 12) send_noise(run);
         if ((close_out && sent >= budget) ||
             (merge_live > 1 && $urandom_range(0, 99) < 3)) begin
            send_item(FUNC_END, run, '0, '0, KIND_CHUNK, '0);
            merge_live--;
         end else begin
            send_offer(run);
         end
         sent++;
      end
   endtask

   // Stimulus and verdict
   initial begin
      int waited;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      merge_live     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single run: key extremes, every overlap kind, ignored words, done
      set_active_runs(5'd1);
      send_item(FUNC_OFFER, 4'd0, '0, 64'h8000_0000_0000_0000, KIND_CHUNK, '0);
      send_item(FUNC_OFFER, 4'd0, 20'hFFFFF, 64'h7FFF_FFFF_FFFF_FFFF, KIND_SPARE,
                32'hFFFF_FFFF);
      send_item(FUNC_OFFER, 4'd5, 20'd7, 64'd7, KIND_CHUNK, 32'h0000_0055);
      send_item(FUNC_END, 4'd3, '0, '0, KIND_CHUNK, '0);
      drain_to_idle();
      set_active_runs(5'd0);
      send_item(FUNC_OFFER, 4'd0, 20'd1, '1, KIND_SELF, 32'hA5A5_0001);
      send_item(FUNC_OFFER, 4'd0, 20'd2, 64'd9, KIND_FULL, 32'h5A5A_0002);
      send_item(FUNC_OFFER, 4'd1, 20'd3, 64'd3, KIND_CHUNK, 32'h0000_0003);
      send_item(FUNC_END, 4'd0, '0, '0, KIND_CHUNK, '0);
      send_item(FUNC_OFFER, 4'd0, 20'd4, 64'd4, KIND_CHUNK, 32'h0000_0004);
      send_item(FUNC_END, 4'd0, '0, '0, KIND_CHUNK, '0);
      drain_to_idle();

      // Runs 1 and 2: ties, signed keys, full-run offers and ends
      set_active_runs(5'd3);
      send_item(FUNC_OFFER, 4'd2, 20'd5, '1, KIND_CHUNK, 32'h0000_00A2);
      send_item(FUNC_OFFER, 4'd2, 20'd0, '0, KIND_SELF, 32'h0000_00EE);
      send_item(FUNC_END, 4'd2, '0, '0, KIND_CHUNK, '0);
      send_item(FUNC_OFFER, 4'd1, 20'd5, '1, KIND_SELF, 32'h0000_00B1);
      send_item(FUNC_OFFER, 4'd1, 20'd5, -64'sd2, KIND_FULL, 32'h0000_00B2);
      send_item(FUNC_OFFER, 4'd1, 20'd4, 64'h7FFF_FFFF_FFFF_FFFF, KIND_CHUNK,
                32'h0000_00B3);
      send_item(FUNC_OFFER, 4'd1, 20'd5, '0, KIND_SPARE, 32'h0000_00B4);
      send_item(FUNC_END, 4'd2, '0, '0, KIND_CHUNK, '0);
      send_item(FUNC_END, 4'd1, '0, '0, KIND_CHUNK, '0);
      drain_to_idle();
      refill_requests.delete();

      // Random merges over the untouched runs, one idle pattern per phase
      set_active_runs(5'd7);
      run_merge(3, 6, 150, 1'b1, 1'b1);
      drain_to_idle();

      send_idle_pct = 70;
      set_active_runs(5'd12);
      run_merge(7, 11, 150, 1'b1, 1'b1);
      drain_to_idle();

      send_idle_pct  = 0;
      recv_stall_pct = 70;
      set_active_runs(5'd16);
      run_merge(12, 15, 150, 1'b1, 1'b0);
      drain_to_idle();

      // Same merge continues with an out-of-range run count that saturates
      send_idle_pct  = 35;
      recv_stall_pct = 35;
      set_active_runs(5'd31);
      run_merge(12, 15, 150, 1'b0, 1'b1);

      // Wait for the last words, then let the block settle
      req_tvalid <= 1'b0;
      waited = 0;
      @(negedge clock);
      while (awaited_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (IDLE_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
